@@ rtl/mesp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesp_pkg - shared types and constants of the music event stream parser
// Parse phases, event kinds, header op codes, controller maps and the
// result record that travels from the parser to the output register.
// ----------------------------------------------------------------------------
package mesp_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2,
		PH_DELAY  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_RELEASE = 3'd0,
		KIND_PLAY    = 3'd1,
		KIND_BEND    = 3'd2,
		KIND_CTRL    = 3'd3,
		KIND_PROGRAM = 3'd4,
		KIND_LOOP    = 3'd5,
		KIND_IGNORED = 3'd6
	} kind_t;

	// header op field
	localparam logic [2:0] OP_RELEASE = 3'd0;
	localparam logic [2:0] OP_PLAY    = 3'd1;
	localparam logic [2:0] OP_BEND    = 3'd2;
	localparam logic [2:0] OP_SYSTEM  = 3'd3;
	localparam logic [2:0] OP_CTRL    = 3'd4;
	localparam logic [2:0] OP_SKIP5   = 3'd5;
	localparam logic [2:0] OP_SKIP6   = 3'd6;

	localparam logic [7:0] SYS_FIRST  = 8'd10;
	localparam logic [7:0] SYS_LAST   = 8'd14;
	localparam logic [7:0] CTRL_PROG  = 8'd0;
	localparam logic [7:0] CTRL_LAST  = 8'd9;
	localparam logic [7:0] SYS_VALUE  = 8'd1;

	localparam int         DELAY_FIELD_W   = 28;
	localparam logic [27:0] DELAY_FIELD_MAX = 28'hFFF_FFFF;
	localparam logic [27:0] LOOP_DELAY      = 28'd1;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  channel;
		logic [7:0]  key;
		logic [7:0]  value;
		logic [27:0] delay;
	} result_t;

	function automatic logic [7:0] sys_ctrl_map(input logic [7:0] d0);
		logic [7:0] num;
		case (d0)
			8'd10:   num = 8'd120;
			8'd11:   num = 8'd123;
			8'd12:   num = 8'd126;
			8'd13:   num = 8'd127;
			8'd14:   num = 8'd121;
			default: num = 8'd0;
		endcase
		return num;
	endfunction

	function automatic logic [7:0] ctrl_map(input logic [7:0] d0);
		logic [7:0] num;
		case (d0)
			8'd1:    num = 8'd0;
			8'd2:    num = 8'd1;
			8'd3:    num = 8'd7;
			8'd4:    num = 8'd10;
			8'd5:    num = 8'd11;
			8'd6:    num = 8'd91;
			8'd7:    num = 8'd93;
			8'd8:    num = 8'd64;
			8'd9:    num = 8'd67;
			default: num = 8'd0;
		endcase
		return num;
	endfunction

	// maps a complete event to its result; delay is filled in by the caller
	function automatic result_t decode_event(input logic [7:0] header,
		input logic [7:0] d0, input logic [7:0] d1);
		result_t    r;
		logic [2:0] op;
		r         = '0;
		r.kind    = KIND_IGNORED;
		op        = header[6:4];
		r.channel = header[3:0];
		case (op)
			OP_RELEASE: begin
				r.kind = KIND_RELEASE;
				r.key  = d0;
			end
			OP_PLAY: begin
				r.kind  = KIND_PLAY;
				r.key   = {1'b0, d0[6:0]};
				r.value = d1;
			end
			OP_BEND: begin
				r.kind = KIND_BEND;
				r.key  = d0;
			end
			OP_SYSTEM: begin
				if (d0 >= SYS_FIRST && d0 <= SYS_LAST) begin
					r.kind  = KIND_CTRL;
					r.key   = sys_ctrl_map(d0);
					r.value = SYS_VALUE;
				end
			end
			OP_CTRL: begin
				if (d0 == CTRL_PROG) begin
					r.kind  = KIND_PROGRAM;
					r.value = d1;
				end else if (d0 <= CTRL_LAST) begin
					r.kind  = KIND_CTRL;
					r.key   = ctrl_map(d0);
					r.value = d1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mesp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesp_parser - byte-level event parser
// Holds the parse phase, the event bytes, the shared velocity and the delay
// accumulator; builds an event's result, or a loop marker, on the byte that ends it.
// ----------------------------------------------------------------------------
module mesp_parser #(
	parameter int DELAY_BITS = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_s1,
	input  logic              last_s1,
	output logic              emit,
	output mesp_pkg::result_t result
);

	localparam int WIDE_W = (DELAY_BITS > mesp_pkg::DELAY_FIELD_W) ?
		DELAY_BITS : mesp_pkg::DELAY_FIELD_W;

	mesp_pkg::phase_t phase_q, phase_d;
	logic [7:0]            header_q, header_d;
	logic [7:0]            first_q, first_d;
	logic [7:0]            second_q, second_d;
	logic [7:0]            velocity_q, velocity_d;
	logic [DELAY_BITS-1:0] acc_q, acc_d, acc_step;
	logic [DELAY_BITS+6:0] acc_shift;
	logic [WIDE_W-1:0]     acc_wide;
	logic [2:0]            op;
	logic                  needs_second;
	logic                  done;
	logic                  acc_sat;

	assign op           = header_q[6:4];
	assign needs_second = (op == mesp_pkg::OP_PLAY && data_s1[7]) ||
		op == mesp_pkg::OP_CTRL || op == mesp_pkg::OP_SKIP5 ||
		op == mesp_pkg::OP_SKIP6;
	assign acc_shift    = {acc_q, data_s1[6:0]};
	// the next group would push bits out of the top
	assign acc_sat      = |acc_q[DELAY_BITS-1 -: 7];

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			mesp_pkg::PH_FIRST: begin
				if (needs_second)
					phase_d = mesp_pkg::PH_SECOND;
				else if (header_q[7])
					phase_d = mesp_pkg::PH_DELAY;
				else
					phase_d = mesp_pkg::PH_HEADER;
			end
			mesp_pkg::PH_SECOND: begin
				phase_d = header_q[7] ? mesp_pkg::PH_DELAY : mesp_pkg::PH_HEADER;
			end
			mesp_pkg::PH_DELAY: begin
				phase_d = data_s1[7] ? mesp_pkg::PH_DELAY : mesp_pkg::PH_HEADER;
			end
			default: phase_d = mesp_pkg::PH_FIRST;
		endcase
		if (last_s1)
			phase_d = mesp_pkg::PH_HEADER;
	end

	// data path and completion
	always_comb begin
		header_d   = header_q;
		first_d    = first_q;
		second_d   = second_q;
		velocity_d = velocity_q;
		acc_step   = acc_q;
		done       = 1'b0;
		case (phase_q)
			mesp_pkg::PH_FIRST: begin
				first_d = data_s1;
				if (!needs_second) begin
					second_d = (op == mesp_pkg::OP_PLAY) ? velocity_q : 8'd0;
					done     = !header_q[7];
				end
			end
			mesp_pkg::PH_SECOND: begin
				second_d = data_s1;
				if (op == mesp_pkg::OP_PLAY)
					velocity_d = data_s1;
				done = !header_q[7];
			end
			mesp_pkg::PH_DELAY: begin
				acc_step = acc_sat ? '1 : acc_shift[DELAY_BITS-1:0];
				done     = !data_s1[7];
			end
			default: begin
				header_d = data_s1;
				acc_step = '0;
			end
		endcase
		acc_d = (done || last_s1) ? '0 : acc_step;
	end

	assign emit     = take && (done || last_s1);
	assign acc_wide = WIDE_W'(acc_step);

	always_comb begin
		result = mesp_pkg::decode_event(header_d, first_d, second_d);
		result.delay = (acc_wide > WIDE_W'(mesp_pkg::DELAY_FIELD_MAX)) ?
			mesp_pkg::DELAY_FIELD_MAX : acc_wide[mesp_pkg::DELAY_FIELD_W-1:0];
		if (last_s1) begin
			result       = '0;
			result.kind  = mesp_pkg::KIND_LOOP;
			result.delay = mesp_pkg::LOOP_DELAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mesp_pkg::PH_HEADER;
			header_q   <= '0;
			first_q    <= '0;
			second_q   <= '0;
			velocity_q <= '0;
			acc_q      <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			header_q   <= header_d;
			first_q    <= first_d;
			second_q   <= second_d;
			velocity_q <= velocity_d;
			acc_q      <= acc_d;
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_s1 |=> phase_q == mesp_pkg::PH_HEADER && acc_q == '0)
		else $error("song end did not restart parsing");

	a_header_to_first: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_s1 && phase_q == mesp_pkg::PH_HEADER
		|=> phase_q == mesp_pkg::PH_FIRST)
		else $error("header beat did not move to first data");

	a_header_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_s1 && phase_q == mesp_pkg::PH_HEADER |-> !emit)
		else $error("header beat completed an event");

endmodule

@@ rtl/mesp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesp_out_reg - result register
// Holds one finished result until the output beat is taken.
// ----------------------------------------------------------------------------
module mesp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mesp_pkg::result_t load_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output mesp_pkg::result_t data_q
);

	logic valid_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load)
			data_q <= load_data;
	end

endmodule

@@ rtl/mus_event_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mus_event_stream_parser - music score event parser
// Turns a score byte stream into note, bend, controller and program events.
// ----------------------------------------------------------------------------
// One score byte is taken per clock while in_ready is high. A byte passes an
// input register, the parser decides from that register whether the byte ends
// an event, and a finished event sits in the output register. Sustained rate
// is one byte per cycle while out_ready is high; a held result stalls the
// parser, and in_ready drops only when the input register is also full.
// delay_ticks saturates at 2^DELAY_BITS - 1 and never exceeds the 28-bit
// field; a byte flagged last_byte ends the current event and yields a loop
// marker instead.
// ----------------------------------------------------------------------------
module mus_event_stream_parser #(
	parameter int DELAY_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [3:0]  channel,
	output logic [7:0]  key,
	output logic [7:0]  value,
	output logic [27:0] delay_ticks
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              space;
	logic              take;
	logic              emit;
	mesp_pkg::result_t result;
	mesp_pkg::result_t out_q;

	assign take     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mesp_parser #(
		.DELAY_BITS(DELAY_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.emit    (emit),
		.result  (result)
	);

	mesp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.load_data (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_q    (out_q)
	);

	assign event_kind  = out_q.kind;
	assign channel     = out_q.channel;
	assign key         = out_q.key;
	assign value       = out_q.value;
	assign delay_ticks = out_q.delay;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the music event stream parser
// Feeds score bytes (a directed table, then random well-formed events mixed
// with noise and early song ends) through the valid/ready input, predicts
// every event, loop marker and saturated delay, and checks each output beat.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_BEATS = 1750;
	localparam int HOLD_OFF     = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;

	// controller numbers packed low entry first
	localparam logic [39:0] SYS_NUMS  = {8'd121, 8'd127, 8'd126, 8'd123, 8'd120};
	localparam logic [71:0] CTRL_NUMS = {8'd67, 8'd64, 8'd93, 8'd91, 8'd11,
		8'd10, 8'd7, 8'd1, 8'd0};

	typedef struct packed {
		logic [7:0]        b;
		logic              last;
		logic              known;
		mesp_pkg::result_t exp;
	} score_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  key;
	logic [7:0]  value;
	logic [27:0] delay_ticks;

	// predictor state
	mesp_pkg::phase_t ps_phase;
	logic [7:0]       ps_header;
	logic [7:0]       ps_first;
	logic [7:0]       ps_second;
	logic [7:0]       ps_velocity;
	logic [27:0]      ps_delay;

	mesp_pkg::result_t expected_events [$];
	score_beat_t       score_q [$];
	mesp_pkg::result_t head;
	int          mismatches = 0;
	int          beats_in = 0;
	int          events_seen = 0;
	int          loops_seen = 0;
	int          saturated_seen = 0;
	int          n_directed;
	int          cycles = 0;

	mus_event_stream_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.channel     (channel),
		.key         (key),
		.value       (value),
		.delay_ticks (delay_ticks)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycles,
				expected_events.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic mesp_pkg::result_t finished_event();
		mesp_pkg::result_t r;
		r         = '0;
		r.kind    = mesp_pkg::KIND_IGNORED;
		r.channel = ps_header[3:0];
		r.delay   = ps_delay;
		case (ps_header[6:4])
			mesp_pkg::OP_RELEASE: begin
				r.kind = mesp_pkg::KIND_RELEASE;
				r.key  = ps_first;
			end
			mesp_pkg::OP_PLAY: begin
				r.kind  = mesp_pkg::KIND_PLAY;
				r.key   = ps_first & 8'h7F;
				r.value = ps_second;
			end
			mesp_pkg::OP_BEND: begin
				r.kind = mesp_pkg::KIND_BEND;
				r.key  = ps_first;
			end
			mesp_pkg::OP_SYSTEM: begin
				if (ps_first >= mesp_pkg::SYS_FIRST && ps_first <= mesp_pkg::SYS_LAST) begin
					r.kind  = mesp_pkg::KIND_CTRL;
					r.key   = SYS_NUMS[(ps_first - mesp_pkg::SYS_FIRST) * 8 +: 8];
					r.value = mesp_pkg::SYS_VALUE;
				end
			end
			mesp_pkg::OP_CTRL: begin
				if (ps_first == mesp_pkg::CTRL_PROG) begin
					r.kind  = mesp_pkg::KIND_PROGRAM;
					r.value = ps_second;
				end else if (ps_first <= mesp_pkg::CTRL_LAST) begin
					r.kind  = mesp_pkg::KIND_CTRL;
					r.key   = CTRL_NUMS[(ps_first - 1) * 8 +: 8];
					r.value = ps_second;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// advances the parser copy by one score byte; returns 1 when a result is due
	function automatic bit predict_score_byte(input logic [7:0] b, input logic last,
		output mesp_pkg::result_t r);
		logic [2:0] op;
		bit         done;
		done = 1'b0;
		r    = '0;
		op   = ps_header[6:4];
		case (ps_phase)
			mesp_pkg::PH_FIRST: begin
				ps_first = b;
				if ((op == mesp_pkg::OP_PLAY && b[7]) || op == mesp_pkg::OP_CTRL
					|| op == mesp_pkg::OP_SKIP5 || op == mesp_pkg::OP_SKIP6) begin
					ps_phase = mesp_pkg::PH_SECOND;
				end else begin
					ps_second = (op == mesp_pkg::OP_PLAY) ? ps_velocity : 8'd0;
					if (ps_header[7])
						ps_phase = mesp_pkg::PH_DELAY;
					else
						done = 1'b1;
				end
			end
			mesp_pkg::PH_SECOND: begin
				ps_second = b;
				if (op == mesp_pkg::OP_PLAY)
					ps_velocity = b;
				if (ps_header[7])
					ps_phase = mesp_pkg::PH_DELAY;
				else
					done = 1'b1;
			end
			mesp_pkg::PH_DELAY: begin
				if (ps_delay > (mesp_pkg::DELAY_FIELD_MAX >> 7))
					ps_delay = mesp_pkg::DELAY_FIELD_MAX;
				else
					ps_delay = {ps_delay[20:0], b[6:0]};
				if (!b[7])
					done = 1'b1;
			end
			default: begin
				ps_header = b;
				ps_delay  = '0;
				ps_phase  = mesp_pkg::PH_FIRST;
			end
		endcase
		if (last) begin
			r.kind   = mesp_pkg::KIND_LOOP;
			r.delay  = mesp_pkg::LOOP_DELAY;
			ps_phase = mesp_pkg::PH_HEADER;
			ps_delay = '0;
			return 1'b1;
		end
		if (done) begin
			r        = finished_event();
			ps_phase = mesp_pkg::PH_HEADER;
			ps_delay = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic score_beat_t raw_beat(input logic [7:0] b, input logic last);
		score_beat_t s;
		s      = '0;
		s.b    = b;
		s.last = last;
		return s;
	endfunction

	function automatic score_beat_t beat_with_result(input logic [7:0] b,
		input logic last, input mesp_pkg::kind_t k, input logic [3:0] ch,
		input logic [7:0] ky, input logic [7:0] v, input logic [27:0] d);
		score_beat_t s;
		s             = raw_beat(b, last);
		s.known       = 1'b1;
		s.exp.kind    = k;
		s.exp.channel = ch;
		s.exp.key     = ky;
		s.exp.value   = v;
		s.exp.delay   = d;
		return s;
	endfunction

	// stimulus, reset and input side
	initial begin
		score_beat_t       sb;
		mesp_pkg::result_t pred;
		logic [7:0]  ev [$];
		logic [7:0]  hdr;
		logic [7:0]  db;
		logic [2:0]  op;
		int          n, k, cut, ends, burst, gap;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		ps_phase    = mesp_pkg::PH_HEADER;
		ps_header   = '0;
		ps_first    = '0;
		ps_second   = '0;
		ps_velocity = '0;
		ps_delay    = '0;

		// directed table
		score_q.push_back(raw_beat(8'h00, 1'b0));
		score_q.push_back(beat_with_result(8'hFF, 1'b0, mesp_pkg::KIND_RELEASE, 4'd0,
			8'hFF, 8'd0, 28'd0));
		score_q.push_back(raw_beat(8'h1F, 1'b0));
		score_q.push_back(raw_beat(8'h85, 1'b0));
		score_q.push_back(beat_with_result(8'h7F, 1'b0, mesp_pkg::KIND_PLAY, 4'd15,
			8'h05, 8'h7F, 28'd0));
		// play without velocity byte reuses the last one
		score_q.push_back(raw_beat(8'h11, 1'b0));
		score_q.push_back(raw_beat(8'h3C, 1'b0));
		// bend with a delay that runs past the field maximum
		score_q.push_back(raw_beat(8'hA3, 1'b0));
		score_q.push_back(raw_beat(8'h40, 1'b0));
		score_q.push_back(raw_beat(8'hFF, 1'b0));
		score_q.push_back(raw_beat(8'hFF, 1'b0));
		score_q.push_back(raw_beat(8'hFF, 1'b0));
		score_q.push_back(raw_beat(8'hFF, 1'b0));
		score_q.push_back(beat_with_result(8'h7F, 1'b0, mesp_pkg::KIND_BEND, 4'd3,
			8'h40, 8'd0, mesp_pkg::DELAY_FIELD_MAX));
		score_q.push_back(raw_beat(8'h3A, 1'b0));
		score_q.push_back(beat_with_result(8'h0D, 1'b0, mesp_pkg::KIND_CTRL, 4'd10,
			8'd127, 8'd1, 28'd0));
		// mapped controller followed by a two-byte delay
		score_q.push_back(raw_beat(8'hC4, 1'b0));
		score_q.push_back(raw_beat(8'h09, 1'b0));
		score_q.push_back(raw_beat(8'h12, 1'b0));
		score_q.push_back(raw_beat(8'h83, 1'b0));
		score_q.push_back(raw_beat(8'h05, 1'b0));
		score_q.push_back(raw_beat(8'h42, 1'b0));
		score_q.push_back(raw_beat(8'h00, 1'b0));
		score_q.push_back(beat_with_result(8'h55, 1'b0, mesp_pkg::KIND_PROGRAM, 4'd2,
			8'd0, 8'h55, 28'd0));
		score_q.push_back(raw_beat(8'h60, 1'b0));
		score_q.push_back(raw_beat(8'h01, 1'b0));
		score_q.push_back(beat_with_result(8'h02, 1'b0, mesp_pkg::KIND_IGNORED, 4'd0,
			8'd0, 8'd0, 28'd0));
		// song ends inside an event, on an event's final byte, and on a header
		score_q.push_back(raw_beat(8'h91, 1'b0));
		score_q.push_back(beat_with_result(8'h80, 1'b1, mesp_pkg::KIND_LOOP, 4'd0,
			8'd0, 8'd0, mesp_pkg::LOOP_DELAY));
		score_q.push_back(raw_beat(8'h2F, 1'b0));
		score_q.push_back(beat_with_result(8'h10, 1'b1, mesp_pkg::KIND_LOOP, 4'd0,
			8'd0, 8'd0, mesp_pkg::LOOP_DELAY));
		score_q.push_back(beat_with_result(8'h00, 1'b1, mesp_pkg::KIND_LOOP, 4'd0,
			8'd0, 8'd0, mesp_pkg::LOOP_DELAY));
		n_directed = score_q.size();

		// random events, some noise and cut-short songs
		while (score_q.size() < n_directed + RANDOM_BEATS) begin
			if ($urandom_range(0, 99) < 6) begin
				score_q.push_back(raw_beat(8'($urandom_range(0, 255)),
					$urandom_range(0, 15) == 0));
			end else begin
				ev.delete();
				op  = 3'($urandom_range(0, 7));
				hdr = {1'($urandom_range(0, 1)), op, 4'($urandom_range(0, 15))};
				ev.push_back(hdr);
				db = 8'($urandom_range(0, 255));
				if (op == mesp_pkg::OP_SYSTEM && $urandom_range(0, 4) != 0)
					db = 8'($urandom_range(mesp_pkg::SYS_FIRST, mesp_pkg::SYS_LAST));
				if (op == mesp_pkg::OP_CTRL && $urandom_range(0, 4) != 0)
					db = 8'($urandom_range(mesp_pkg::CTRL_PROG, mesp_pkg::CTRL_LAST));
				ev.push_back(db);
				if ((op == mesp_pkg::OP_PLAY && db[7]) || op == mesp_pkg::OP_CTRL
					|| op == mesp_pkg::OP_SKIP5 || op == mesp_pkg::OP_SKIP6)
					ev.push_back(8'($urandom_range(0, 255)));
				if (hdr[7]) begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
					for (k = 0; k < n; k++) begin
						db = 8'($urandom_range(0, 127));
						if (k != n - 1)
							db[7] = 1'b1;
						ev.push_back(db);
					end
				end
				cut  = ev.size();
				ends = $urandom_range(0, 39);
				if (ends == 0)
					cut = $urandom_range(1, ev.size());
				for (k = 0; k < cut; k++)
					score_q.push_back(raw_beat(ev[k], ends <= 2 && k == cut - 1));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		burst = 0;
		while (score_q.size() != 0) begin
			sb = score_q.pop_front();
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst--;
			in_valid  <= 1'b1;
			data_byte <= sb.b;
			last_byte <= sb.last;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			beats_in++;
			if (predict_score_byte(sb.b, sb.last, pred))
				expected_events.push_back(sb.known ? sb.exp : pred);
			@(negedge clk);
		end
		in_valid <= 1'b0;

		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d score bytes sent (%0d from the directed table), %0d events checked",
			beats_in, n_directed, events_seen);
		$display("%0d loop markers and %0d saturated delays among them",
			loops_seen, saturated_seen);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// output side: stall pattern plus one long hold-off once traffic is going
	initial begin
		int seg, stall_pct;
		bit held;
		out_ready = 1'b0;
		held      = 1'b0;
		seg       = 0;
		stall_pct = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && beats_in >= 400) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			if (seg == 0) begin
				seg = $urandom_range(20, 150);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			seg--;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				$error("unexpected result beat: kind %0d channel %0d key %0d value %0d delay %0d",
					event_kind, channel, key, value, delay_ticks);
				mismatches++;
			end else begin
				head = expected_events.pop_front();
				events_seen++;
				if (head.kind == mesp_pkg::KIND_LOOP)
					loops_seen++;
				if (head.delay == mesp_pkg::DELAY_FIELD_MAX)
					saturated_seen++;
				if (event_kind !== head.kind) begin
					$error("event_kind: expected %0d, got %0d", head.kind, event_kind);
					mismatches++;
				end
				if (channel !== head.channel) begin
					$error("channel: expected %0d, got %0d", head.channel, channel);
					mismatches++;
				end
				if (key !== head.key) begin
					$error("key: expected %0d, got %0d", head.key, key);
					mismatches++;
				end
				if (value !== head.value) begin
					$error("value: expected %0d, got %0d", head.value, value);
					mismatches++;
				end
				if (delay_ticks !== head.delay) begin
					$error("delay_ticks: expected %0d, got %0d", head.delay, delay_ticks);
					mismatches++;
				end
			end
		end
	end

endmodule
